// ===== design/int32_power_by_squaring_assert.svh =====
// ----------------------------------------------------------------------------
// int32_power_by_squaring assertion macros
// Concurrent assertion wrappers on clk_i / rst_ni; empty under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef INT32_POWER_BY_SQUARING_ASSERT_SVH
`define INT32_POWER_BY_SQUARING_ASSERT_SVH

`ifndef SYNTHESIS

// implication or plain property, checked on every clock out of reset
`define IPBS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ipbs assertion failed");

// condition that must never be seen
`define IPBS_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("ipbs forbidden condition seen");

`else

`define IPBS_ASSERT(lbl, prop)
`define IPBS_ASSERT_NEVER(lbl, expr)

`endif

`endif

// ===== design/ipbs_pkg.sv =====
// ----------------------------------------------------------------------------
// ipbs_pkg
// Shared types for the power-by-squaring cell chain.
// ----------------------------------------------------------------------------
package ipbs_pkg;

  // per-stage control carried along the chain with each item
  typedef struct packed {
    logic valid;
    logic done;  // no more exponent bits to process
    logic ovf;   // signed overflow or negative exponent seen
  } ipbs_ctrl_t;

endpackage

// ===== design/ipbs_if.sv =====
// ----------------------------------------------------------------------------
// ipbs_in_if / ipbs_out_if
// Valid/ready channels for operands and results.
// ----------------------------------------------------------------------------
interface ipbs_in_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] base;
  logic signed [DATA_WIDTH-1:0] exponent;

  modport source (output valid, output base, output exponent, input ready);
  modport sink   (input valid, input base, input exponent, output ready);
endinterface

interface ipbs_out_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] power;
  logic                         overflow;

  modport source (output valid, output power, output overflow, input ready);
  modport sink   (input valid, input power, input overflow, output ready);
endinterface

// ===== design/ipbs_cell.sv =====
// ----------------------------------------------------------------------------
// ipbs_cell
// One square-and-multiply step for one exponent bit, registered.
// ----------------------------------------------------------------------------
module ipbs_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  ipbs_pkg::ipbs_ctrl_t   ctrl_i,
  input  logic [DATA_WIDTH-1:0]  acc_mag_i,
  input  logic                   acc_neg_i,
  input  logic [DATA_WIDTH-1:0]  x_mag_i,
  input  logic                   x_neg_i,
  input  logic [DATA_WIDTH-1:0]  exp_i,
  output ipbs_pkg::ipbs_ctrl_t   ctrl_o,
  output logic [DATA_WIDTH-1:0]  acc_mag_o,
  output logic                   acc_neg_o,
  output logic [DATA_WIDTH-1:0]  x_mag_o,
  output logic                   x_neg_o,
  output logic [DATA_WIDTH-1:0]  exp_o
);
  import ipbs_pkg::*;

  localparam int W = DATA_WIDTH;
  localparam logic [2*W-1:0] PosLimit = {{(W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [2*W-1:0] NegLimit = {{W{1'b0}}, 1'b1, {(W-1){1'b0}}};

  logic [2*W-1:0] prod_a;
  logic [2*W-1:0] prod_s;
  logic           neg_a;
  logic           ovf_a;
  logic           ovf_s;
  logic [W-1:0]   exp_nx;

  ipbs_ctrl_t     ctrl_d,    ctrl_q;
  logic [W-1:0]   acc_mag_d, acc_mag_q;
  logic           acc_neg_d, acc_neg_q;
  logic [W-1:0]   x_mag_d,   x_mag_q;
  logic           x_neg_d,   x_neg_q;

  // magnitudes are unsigned; a negative product may reach 2^(W-1)
  assign prod_a = {{W{1'b0}}, acc_mag_i} * {{W{1'b0}}, x_mag_i};
  assign prod_s = {{W{1'b0}}, x_mag_i} * {{W{1'b0}}, x_mag_i};
  assign neg_a  = acc_neg_i ^ x_neg_i;
  assign ovf_a  = prod_a > (neg_a ? NegLimit : PosLimit);
  assign ovf_s  = prod_s > PosLimit;
  assign exp_nx = exp_i >> 1;

  always_comb begin
    ctrl_d    = ctrl_i;
    acc_mag_d = acc_mag_i;
    acc_neg_d = acc_neg_i;
    x_mag_d   = x_mag_i;
    x_neg_d   = x_neg_i;
    if (ctrl_i.valid && !ctrl_i.done) begin
      if (exp_i[0] && ovf_a) begin
        ctrl_d.ovf  = 1'b1;
        ctrl_d.done = 1'b1;
      end else begin
        if (exp_i[0]) begin
          acc_mag_d = prod_a[W-1:0];
          acc_neg_d = neg_a && (prod_a != '0);
        end
        if (exp_nx == '0) begin
          ctrl_d.done = 1'b1;
        end else if (ovf_s) begin
          ctrl_d.ovf  = 1'b1;
          ctrl_d.done = 1'b1;
        end else begin
          x_mag_d = prod_s[W-1:0];
          x_neg_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_mag_q <= acc_mag_d;
      acc_neg_q <= acc_neg_d;
      x_mag_q   <= x_mag_d;
      x_neg_q   <= x_neg_d;
      exp_o     <= exp_nx;
    end
  end

  assign ctrl_o    = ctrl_q;
  assign acc_mag_o = acc_mag_q;
  assign acc_neg_o = acc_neg_q;
  assign x_mag_o   = x_mag_q;
  assign x_neg_o   = x_neg_q;

endmodule

// ===== design/int32_power_by_squaring.sv =====
// ----------------------------------------------------------------------------
// int32_power_by_squaring
// Signed integer power by right-to-left square-and-multiply on a cell chain.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries base and exponent (signed DATA_WIDTH bits); out_o carries
//   power and overflow. Both are valid/ready; an item moves when both are high.
//   The operands are registered and sign-split, then pass a row of
//   DATA_WIDTH-1 cells, one cell per exponent bit, each with a multiplier for
//   the running product and one for the squaring. A final register turns the
//   magnitude back into two's complement.
//   The result passes the front register, the DATA_WIDTH-1 cells and the
//   output register in that order. Throughput: one item per cycle unless
//   stalled by out_o.ready; the cell chain is fully pipelined.
//   Overflow (negative exponent, or any product or square beyond signed
//   DATA_WIDTH bits) gives power 0 and overflow 1. Exponent 0 gives 1.
//   Reset clears all valid bits; no result is pending after reset.
//   When out_o.ready is low with a result waiting, the whole chain holds and
//   in_i.ready drops in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "int32_power_by_squaring_assert.svh"

module int32_power_by_squaring #(
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ipbs_in_if.sink   in_i,
  ipbs_out_if.source out_o
);
  import ipbs_pkg::*;

  localparam int W      = DATA_WIDTH;
  localparam int NCELLS = DATA_WIDTH - 1;

  logic         en;

  ipbs_ctrl_t   p_ctrl    [NCELLS+1];
  logic [W-1:0] p_acc_mag [NCELLS+1];
  logic         p_acc_neg [NCELLS+1];
  logic [W-1:0] p_x_mag   [NCELLS+1];
  logic         p_x_neg   [NCELLS+1];
  logic [W-1:0] p_exp     [NCELLS+1];

  ipbs_ctrl_t   ctrl0_d, ctrl0_q;
  logic [W-1:0] base_mag;
  logic [W-1:0] x0_mag_q;
  logic         x0_neg_q;
  logic [W-1:0] exp0_q;

  logic         out_valid_d, out_valid_q;
  logic [W-1:0] power_d,     power_q;
  logic         ovf_d,       ovf_q;

  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // front stage: split base into sign and magnitude
  assign base_mag = in_i.base[W-1] ? (~in_i.base + 1'b1) : in_i.base;

  always_comb begin
    ctrl0_d.valid = in_i.valid;
    ctrl0_d.done  = in_i.exponent[W-1];
    ctrl0_d.ovf   = in_i.exponent[W-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl0_q <= '0;
    end else if (en) begin
      ctrl0_q <= ctrl0_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_mag_q <= base_mag;
      x0_neg_q <= in_i.base[W-1];
      exp0_q   <= in_i.exponent;
    end
  end

  assign p_ctrl[0]    = ctrl0_q;
  assign p_acc_mag[0] = {{(W-1){1'b0}}, 1'b1};
  assign p_acc_neg[0] = 1'b0;
  assign p_x_mag[0]   = x0_mag_q;
  assign p_x_neg[0]   = x0_neg_q;
  assign p_exp[0]     = exp0_q;

  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    ipbs_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .ctrl_i   (p_ctrl[k]),
      .acc_mag_i(p_acc_mag[k]),
      .acc_neg_i(p_acc_neg[k]),
      .x_mag_i  (p_x_mag[k]),
      .x_neg_i  (p_x_neg[k]),
      .exp_i    (p_exp[k]),
      .ctrl_o   (p_ctrl[k+1]),
      .acc_mag_o(p_acc_mag[k+1]),
      .acc_neg_o(p_acc_neg[k+1]),
      .x_mag_o  (p_x_mag[k+1]),
      .x_neg_o  (p_x_neg[k+1]),
      .exp_o    (p_exp[k+1])
    );
  end

  // back stage: restore two's complement, zero on overflow
  always_comb begin
    out_valid_d = p_ctrl[NCELLS].valid;
    ovf_d       = p_ctrl[NCELLS].ovf;
    if (p_ctrl[NCELLS].ovf) begin
      power_d = '0;
    end else if (p_acc_neg[NCELLS]) begin
      power_d = ~p_acc_mag[NCELLS] + 1'b1;
    end else begin
      power_d = p_acc_mag[NCELLS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      power_q <= power_d;
      ovf_q   <= ovf_d;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.power    = power_q;
  assign out_o.overflow = ovf_q;

  // every item has used up its exponent bits by the end of the chain
  `IPBS_ASSERT(a_chain_done, p_ctrl[NCELLS].valid |-> p_ctrl[NCELLS].done)
  // overflow always forces a zero power
  `IPBS_ASSERT(a_ovf_zero, (out_valid_q && ovf_q) |-> (power_q == '0))
  // negative exponent is flagged at the front stage
  `IPBS_ASSERT(a_neg_exp, (in_i.valid && in_i.ready && in_i.exponent[W-1])
                          |=> (p_ctrl[0].ovf && p_ctrl[0].done))
  // overflow without done would let a later cell overwrite the item
  `IPBS_ASSERT_NEVER(a_ovf_not_done, p_ctrl[NCELLS].ovf && !p_ctrl[NCELLS].done)

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks int32_power_by_squaring against a built-in square-and-multiply
// predictor: directed corner operands, then mostly in-range random powers
// mixed with raw random bits, with bursty input and a stalling result side.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DW = 32;
  localparam int ITEM_TARGET = 550;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD = 400;
  localparam int HOLD_AFTER = 120;
  localparam longint POS_MAX = (longint'(1) << (DW - 1)) - 1;
  localparam longint NEG_MIN = -(longint'(1) << (DW - 1));
  localparam logic signed [DW-1:0] S_MAX = POS_MAX[DW-1:0];
  localparam logic signed [DW-1:0] S_MIN = NEG_MIN[DW-1:0];

  typedef struct {
    logic signed [DW-1:0] base;
    logic signed [DW-1:0] exponent;
  } operand_t;

  typedef struct {
    logic signed [DW-1:0] power;
    logic                 overflow;
  } power_t;

  logic clk_i;
  logic rst_ni;

  ipbs_in_if  #(.DATA_WIDTH(DW)) opnd_if ();
  ipbs_out_if #(.DATA_WIDTH(DW)) res_if ();

  int32_power_by_squaring #(.DATA_WIDTH(DW)) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (opnd_if),
    .out_o  (res_if)
  );

  operand_t operand_q[$];
  power_t   power_expect_q[$];
  int       error_count = 0;

  // right-to-left square-and-multiply, stopping at the first overflow
  function automatic power_t calc_power(logic signed [DW-1:0] base,
                                        logic signed [DW-1:0] exponent);
    power_t       res;
    longint       acc;
    longint       sq;
    longint       prod;
    logic [DW-1:0] ebits;
    res.power = '0;
    res.overflow = 1'b1;
    if (exponent[DW-1]) begin
      return res;
    end
    acc = 1;
    sq = longint'(base);
    ebits = exponent;
    for (int i = 0; i < DW; i++) begin
      if (ebits[0]) begin
        prod = acc * sq;
        if (prod > POS_MAX || prod < NEG_MIN) return res;
        acc = prod;
      end
      ebits = ebits >> 1;
      if (ebits == '0) break;
      prod = sq * sq;
      if (prod > POS_MAX || prod < NEG_MIN) return res;
      sq = prod;
    end
    res.power = acc[DW-1:0];
    res.overflow = 1'b0;
    return res;
  endfunction

  function automatic void add_item(logic signed [DW-1:0] base,
                                   logic signed [DW-1:0] exponent);
    operand_t op;
    op.base = base;
    op.exponent = exponent;
    operand_q.push_back(op);
  endfunction

  // random operands, weighted toward powers that stay in range
  function automatic operand_t random_operand();
    operand_t op;
    int unsigned w;
    int unsigned mag;
    op.base = $urandom;
    op.exponent = $urandom;
    case ($urandom_range(0, 9))
      0: ;  // raw bits on both fields
      1: op.exponent = $urandom_range(0, 3);
      2, 3: begin
        op.base = $signed($urandom_range(0, 8)) - 4;
        w = $urandom_range(1, 31);
        op.exponent = $urandom & ((32'h1 << w) - 1);
      end
      4, 5, 6: begin
        w = $urandom_range(1, 30);
        mag = $urandom_range(0, (32'h1 << w) - 1);
        op.base = $urandom_range(0, 1) ? -$signed(mag) : $signed(mag);
        op.exponent = $urandom_range(0, 31 / w + 1);
      end
      7: op.exponent = $urandom | 32'h8000_0000;
      8: begin
        op.base = $signed($urandom_range(0, 2)) - 1;
        op.exponent = $urandom & 32'h7fff_ffff;
      end
      default: begin
        op.base = $signed($urandom_range(46335, 46345));
        if ($urandom_range(0, 1)) op.base = -op.base;
        op.exponent = $urandom_range(1, 3);
      end
    endcase
    return op;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------- operand driver: bursts with random gaps ----------------
  int unsigned burst_left;
  int unsigned gap_left;
  operand_t    drv_next;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opnd_if.valid    <= 1'b0;
      opnd_if.base     <= '0;
      opnd_if.exponent <= '0;
      burst_left       <= 0;
      gap_left         <= 0;
    end else begin
      if (opnd_if.valid && opnd_if.ready) begin
        power_expect_q.push_back(calc_power(opnd_if.base, opnd_if.exponent));
      end
      if (!opnd_if.valid || opnd_if.ready) begin
        if (gap_left != 0) begin
          gap_left      <= gap_left - 1;
          opnd_if.valid <= 1'b0;
        end else if (operand_q.size() != 0) begin
          drv_next = operand_q.pop_front();
          opnd_if.valid    <= 1'b1;
          opnd_if.base     <= drv_next.base;
          opnd_if.exponent <= drv_next.exponent;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          opnd_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- result monitor and stall pattern ----------------
  int unsigned rx_cycle;
  int unsigned hold_left;
  logic        hold_done;
  int unsigned results_seen;
  power_t      seen_expect;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      rx_cycle     <= 0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
      results_seen <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (power_expect_q.size() == 0) begin
          $display("%0t: unexpected item: power %0d overflow %0b", $time,
                   res_if.power, res_if.overflow);
          error_count++;
        end else begin
          seen_expect = power_expect_q.pop_front();
          if (res_if.power !== seen_expect.power) begin
            $display("%0t: power mismatch: expected %0d actual %0d", $time,
                     seen_expect.power, res_if.power);
            error_count++;
          end
          if (res_if.overflow !== seen_expect.overflow) begin
            $display("%0t: overflow mismatch: expected %0b actual %0b", $time,
                     seen_expect.overflow, res_if.overflow);
            error_count++;
          end
        end
        results_seen <= results_seen + 1;
      end
      rx_cycle <= rx_cycle + 1;
      if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        res_if.ready <= 1'b0;
      end else if (!hold_done && results_seen == HOLD_AFTER) begin
        // long back-pressure: the chain fills and the input must stall
        hold_done    <= 1'b1;
        hold_left    <= LONG_HOLD;
        res_if.ready <= 1'b0;
      end else begin
        case (rx_cycle[9:8])
          2'd0: res_if.ready <= 1'b1;
          2'd1: res_if.ready <= ($urandom_range(0, 3) != 0);
          2'd2: res_if.ready <= ((rx_cycle % 7) >= 2);
          default: res_if.ready <= $urandom_range(0, 1);
        endcase
      end
    end
  end

  // ---------------- watchdog ----------------
  int unsigned cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // ---------------- stimulus and end of run ----------------
  initial begin
    rst_ni           = 1'b0;
    opnd_if.valid    = 1'b0;
    opnd_if.base     = '0;
    opnd_if.exponent = '0;
    res_if.ready     = 1'b0;

    add_item(0, 0);            // zero to the zero is one
    add_item(0, 123);
    add_item(-7, 0);
    add_item(5, -1);           // negative exponent
    add_item(0, S_MIN);
    add_item(S_MIN, 0);
    add_item(S_MIN, 1);        // most negative base, first power
    add_item(S_MIN, 2);        // its square overflows
    add_item(S_MAX, 1);
    add_item(S_MAX, 2);
    add_item(S_MAX, S_MAX);
    add_item(-1, S_MAX);
    add_item(-1, S_MAX - 1);
    add_item(1, S_MAX);
    add_item(0, S_MAX);
    add_item(2, 30);
    add_item(2, 31);
    add_item(-2, 31);          // lands exactly on the most negative value
    add_item(-2, 32);          // squaring overflows before the top bit
    add_item(46340, 2);
    add_item(46341, 2);
    add_item(-46341, 3);
    add_item(256, 4);
    add_item(3, 19);
    add_item(-3, 19);

    for (int i = 0; i < ITEM_TARGET; i++) begin
      operand_q.push_back(random_operand());
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (operand_q.size() != 0 || opnd_if.valid) @(posedge clk_i);
    while (power_expect_q.size() != 0) @(posedge clk_i);
    repeat (DW + 8) @(posedge clk_i);

    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/ipbs_pkg.sv
design/ipbs_if.sv
design/ipbs_cell.sv
design/int32_power_by_squaring.sv
verif/testbench.sv
